[sv/hpt_pkg.sv]
// Shared types, constants and helpers for the homogeneous point transform.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hpt_pkg;

    // Fixed-point format of coordinates and matrix entries.
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int FIELD_W    = 32;
    localparam int HALF_W     = 32;
    localparam int REG_W      = 64;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int ADDR_LSB   = $clog2(REG_W / 8);
    localparam int APB_ADDR_W = REG_IDX_W + ADDR_LSB;

    localparam int ROWS   = 4;
    localparam int COLS   = 4;
    localparam int LANES  = 3;
    localparam int ACC_W  = 64;
    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int NUM_W  = ACC_W + FRAC_BITS;

    localparam logic [COORD_WIDTH-1:0] LIM_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] LIM_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [ACC_W-1:0]              mag_t;

    typedef coord_t [ROWS-1:0][COLS-1:0] matrix_t;
    typedef acc_t [ROWS-1:0]             dot_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic signed [FIELD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic                      range_fault;
    } result_t;

    typedef struct packed {
        mag_t nm;
        logic neg;
        logic num_neg;
        logic num_zero;
    } mag_lane_t;

    typedef struct packed {
        mag_t                   rem;
        logic [COORD_WIDTH-1:0] quo;
        logic [COORD_WIDTH-1:0] nlow;
        logic                   neg;
        logic                   num_neg;
        logic                   num_zero;
        logic                   ovf;
    } div_lane_t;

    // Reset value of a matrix register: the identity matrix.
    function automatic logic [REG_W-1:0] reg_reset(input logic [REG_IDX_W-1:0] idx);
        logic [REG_IDX_W-2:0] row;
        logic [REG_W-1:0]     val;
        row = idx[REG_IDX_W-1:1];
        val = '0;
        if (row[1] == idx[0]) begin
            val = (REG_W'(1) << FRAC_BITS) << (row[0] ? HALF_W : 0);
        end
        return val;
    endfunction

endpackage

`default_nettype wire

[sv/hpt_cfg_regs.sv]
// APB register file holding the 4x4 transform matrix.
// Depends on hpt_pkg.
`default_nettype none

module hpt_cfg_regs import hpt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]      pwdata,
    output logic [REG_W-1:0]      prdata,
    output logic                  pready,
    output matrix_t               matrix
);

    logic [REG_W-1:0]     regs_reg [NUM_REGS];
    logic [REG_IDX_W-1:0] idx;

    assign idx    = paddr[APB_ADDR_W-1:ADDR_LSB];
    assign prdata = regs_reg[idx];
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= reg_reset(REG_IDX_W'(i));
            end
        end else if (psel && penable && pwrite) begin
            regs_reg[idx] <= pwdata;
        end
    end

    // Columns 0 and 2 sit in the low half of a word, columns 1 and 3 in the high half.
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                matrix[r][c] = regs_reg[REG_IDX_W'(2 * r + (c >> 1))]
                                       [(c & 1) * HALF_W +: COORD_WIDTH];
            end
        end
    end

endmodule

`default_nettype wire

[sv/hpt_dot_pipe.sv]
// Three-stage pipeline forming the four row dot products of a point with the matrix.
// Depends on hpt_pkg.
`default_nettype none

module hpt_dot_pipe import hpt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  matrix_t matrix,
    input  logic    in_valid,
    output logic    in_ready,
    input  point_t  in_point,
    output logic    out_valid,
    input  logic    out_ready,
    output dot_t    out_dot
);

    logic   vld_a_reg, vld_b_reg, vld_c_reg;
    logic   adv_a, adv_b, adv_c;
    prod_t  prod_reg  [ROWS][LANES];
    coord_t bias_reg  [ROWS];
    acc_t   sum01_reg [ROWS];
    acc_t   sum2b_reg [ROWS];
    dot_t   dot_reg;
    coord_t pt [LANES];

    assign adv_c    = !vld_c_reg || out_ready;
    assign adv_b    = !vld_b_reg || adv_c;
    assign adv_a    = !vld_a_reg || adv_b;
    assign in_ready = adv_a;

    assign out_valid = vld_c_reg;
    assign out_dot   = dot_reg;

    assign pt[0] = coord_t'(in_point.point_x[COORD_WIDTH-1:0]);
    assign pt[1] = coord_t'(in_point.point_y[COORD_WIDTH-1:0]);
    assign pt[2] = coord_t'(in_point.point_z[COORD_WIDTH-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end else begin
            if (adv_a) vld_a_reg <= in_valid;
            if (adv_b) vld_b_reg <= vld_a_reg;
            if (adv_c) vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int r = 0; r < ROWS; r++) begin
            if (adv_a) begin
                for (int c = 0; c < LANES; c++) begin
                    prod_reg[r][c] <= prod_t'(matrix[r][c]) * prod_t'(pt[c]);
                end
                bias_reg[r] <= matrix[r][COLS-1];
            end
            // Products carry twice the fraction bits; the shift floors them back.
            if (adv_b) begin
                sum01_reg[r] <= acc_t'(prod_reg[r][0] >>> FRAC_BITS)
                              + acc_t'(prod_reg[r][1] >>> FRAC_BITS);
                sum2b_reg[r] <= acc_t'(prod_reg[r][2] >>> FRAC_BITS) + acc_t'(bias_reg[r]);
            end
            if (adv_c) begin
                dot_reg[r] <= sum01_reg[r] + sum2b_reg[r];
            end
        end
    end

endmodule

`default_nettype wire

[sv/hpt_div_pipe.sv]
// Pipelined perspective divide: three restoring dividers, one quotient bit per stage,
// followed by saturation. Depends on hpt_pkg.
`default_nettype none

module hpt_div_pipe import hpt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  dot_t    in_dot,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int NSTEP = COORD_WIDTH;

    logic      vld_m_reg;
    mag_lane_t mag_reg [LANES];
    mag_t      dm_m_reg;
    logic      dzero_m_reg;

    logic      vld_reg   [NSTEP+1];
    div_lane_t lane_reg  [NSTEP+1][LANES];
    mag_t      dm_reg    [NSTEP+1];
    logic      dzero_reg [NSTEP+1];

    logic      vld_o_reg;
    result_t   out_reg;

    logic             adv_m, adv_o;
    logic [NSTEP:0]   adv_s;
    div_lane_t        init_next [LANES];
    div_lane_t        step_next [NSTEP][LANES];
    result_t          out_next;
    mag_lane_t        mag_next  [LANES];
    mag_t             dm_next;

    always_comb begin
        adv_o        = !vld_o_reg || out_ready;
        adv_s[NSTEP] = !vld_reg[NSTEP] || adv_o;
        for (int k = NSTEP - 1; k >= 0; k--) begin
            adv_s[k] = !vld_reg[k] || adv_s[k+1];
        end
        adv_m = !vld_m_reg || adv_s[0];
    end

    assign in_ready  = adv_m;
    assign out_valid = vld_o_reg;
    assign out_data  = out_reg;

    // Sign and magnitude of numerators and divisor.
    always_comb begin
        dm_next = in_dot[ROWS-1][ACC_W-1] ? mag_t'(-in_dot[ROWS-1]) : mag_t'(in_dot[ROWS-1]);
        for (int l = 0; l < LANES; l++) begin
            mag_next[l].num_neg  = in_dot[l][ACC_W-1];
            mag_next[l].nm       = in_dot[l][ACC_W-1] ? mag_t'(-in_dot[l]) : mag_t'(in_dot[l]);
            mag_next[l].neg      = in_dot[l][ACC_W-1] ^ in_dot[ROWS-1][ACC_W-1];
            mag_next[l].num_zero = (in_dot[l] == '0);
        end
    end

    // The scaled numerator bits above the result width must stay below the divisor,
    // otherwise the quotient cannot fit and the lane saturates.
    always_comb begin
        logic [NUM_W-1:0] numer;
        logic [NUM_W-1:0] hi;
        for (int l = 0; l < LANES; l++) begin
            numer = {mag_reg[l].nm, {FRAC_BITS{1'b0}}};
            hi    = numer >> COORD_WIDTH;
            init_next[l].rem      = hi[ACC_W-1:0];
            init_next[l].quo      = '0;
            init_next[l].nlow     = numer[COORD_WIDTH-1:0];
            init_next[l].neg      = mag_reg[l].neg;
            init_next[l].num_neg  = mag_reg[l].num_neg;
            init_next[l].num_zero = mag_reg[l].num_zero;
            init_next[l].ovf      = (hi >= NUM_W'(dm_m_reg));
        end
    end

    always_comb begin
        logic [ACC_W:0] trial;
        for (int k = 0; k < NSTEP; k++) begin
            for (int l = 0; l < LANES; l++) begin
                trial = {lane_reg[k][l].rem, lane_reg[k][l].nlow[COORD_WIDTH-1]};
                step_next[k][l]      = lane_reg[k][l];
                step_next[k][l].nlow = {lane_reg[k][l].nlow[COORD_WIDTH-2:0], 1'b0};
                if (trial >= {1'b0, dm_reg[k]}) begin
                    step_next[k][l].rem = trial[ACC_W-1:0] - dm_reg[k];
                    step_next[k][l].quo = {lane_reg[k][l].quo[COORD_WIDTH-2:0], 1'b1};
                end else begin
                    step_next[k][l].rem = trial[ACC_W-1:0];
                    step_next[k][l].quo = {lane_reg[k][l].quo[COORD_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic [COORD_WIDTH-1:0] lim;
        logic [COORD_WIDTH-1:0] mag;
        logic [COORD_WIDTH-1:0] res [LANES];
        logic                   sat;
        logic                   fault;
        div_lane_t              cur;
        fault = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            cur = lane_reg[NSTEP][l];
            lim = cur.neg ? LIM_NEG : LIM_POS;
            sat = cur.ovf || (cur.quo > lim);
            mag = sat ? lim : cur.quo;
            res[l] = cur.neg ? -mag : mag;
            if (dzero_reg[NSTEP]) begin
                res[l] = cur.num_zero ? '0 : (cur.num_neg ? LIM_NEG : LIM_POS);
                sat    = 1'b1;
            end
            fault = fault | sat;
        end
        out_next.out_x       = FIELD_W'(coord_t'(res[0]));
        out_next.out_y       = FIELD_W'(coord_t'(res[1]));
        out_next.out_z       = FIELD_W'(coord_t'(res[2]));
        out_next.range_fault = fault;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_m_reg <= 1'b0;
            vld_o_reg <= 1'b0;
            for (int k = 0; k <= NSTEP; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else begin
            if (adv_m) vld_m_reg <= in_valid;
            if (adv_s[0]) vld_reg[0] <= vld_m_reg;
            for (int k = 1; k <= NSTEP; k++) begin
                if (adv_s[k]) vld_reg[k] <= vld_reg[k-1];
            end
            if (adv_o) vld_o_reg <= vld_reg[NSTEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_m) begin
            mag_reg     <= mag_next;
            dm_m_reg    <= dm_next;
            dzero_m_reg <= (in_dot[ROWS-1] == '0);
        end
        if (adv_s[0]) begin
            lane_reg[0]  <= init_next;
            dm_reg[0]    <= dm_m_reg;
            dzero_reg[0] <= dzero_m_reg;
        end
        for (int k = 1; k <= NSTEP; k++) begin
            if (adv_s[k]) begin
                lane_reg[k]  <= step_next[k-1];
                dm_reg[k]    <= dm_reg[k-1];
                dzero_reg[k] <= dzero_reg[k-1];
            end
        end
        if (adv_o) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

[sv/homogeneous_point_transform_core.sv]
// Top level of the 4x4 homogeneous point transform with perspective divide.
// Depends on hpt_pkg, hpt_cfg_regs, hpt_dot_pipe and hpt_div_pipe.
`default_nettype none

// Takes one Q16.16 point per request and returns one transformed point per request,
// in order. A new point is accepted every cycle while the output is not stalled. The
// divider resolves one quotient bit per pipeline stage after three stages of multiply
// and sum, and then saturates the result. Every stage holds its data
// while the output is stalled, and empty stages still take new points. The matrix is
// written through the APB port, two entries per 64-bit register at byte address 8*i,
// and resets to identity; write it only while no points are in flight.
module homogeneous_point_transform_core import hpt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  point_t                s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]      pwdata,
    output logic [REG_W-1:0]      prdata,
    output logic                  pready
);

    matrix_t matrix;
    logic    dot_valid, dot_ready;
    dot_t    dot;

    hpt_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .matrix  (matrix)
    );

    hpt_dot_pipe u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .matrix    (matrix),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_point  (s_data),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .out_dot   (dot)
    );

    hpt_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dot_valid),
        .in_ready  (dot_ready),
        .in_dot    (dot),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // With the output stage empty, every stage can move, so a request is always taken.
    assert property (@(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready)
        else $error("input stalled while the output stage is empty");

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result presented right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
                     m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result dropped or changed");

endmodule

`default_nettype wire
